>>> rtl/tcw_pkg.sv
// Package for the text console cell writer.
// Holds the request/response transaction types, operation codes,
// character constants and the controller state type. No dependencies.
package tcw_pkg;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = 16;

  // Operation codes carried in the func field
  localparam logic [2:0] FUNC_PUT_CHAR   = 3'd0;
  localparam logic [2:0] FUNC_CLEAR      = 3'd1;
  localparam logic [2:0] FUNC_SET_CURSOR = 3'd2;
  localparam logic [2:0] FUNC_SET_COLOR  = 3'd3;
  localparam logic [2:0] FUNC_READ_CELL  = 3'd4;

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_RETURN  = 8'd13;
  localparam logic [7:0] CH_SPACE   = 8'd32;

  localparam logic [7:0] ATTR_RESET = 8'h0F;

  typedef struct packed {
    logic [2:0]       func;
    logic [7:0]       char_code;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic [3:0]       foreground;
    logic [3:0]       background;
  } req_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_column;
    logic [ROW_W-1:0]  cursor_line;
    logic              scrolled;
    logic [CELL_W-1:0] cell_word;
  } rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SWEEP,
    S_DONE
  } state_t;

endpackage

>>> rtl/text_console_cell_writer.sv
// Text console cell writer: top level with cursor, attribute and sweep control.
// Depends on tcw_pkg and tcw_screen_ram.
//
// Usage:
//   Requests enter on req/req_valid/req_ready, one transaction per operation
//   (put char, clear, set cursor, set color, read cell). Each request gives
//   exactly one response on rsp/rsp_valid/rsp_ready with the cursor after the
//   operation, the scroll flag and, for read cell, the cell word.
//   Timing: put char without scroll, set cursor, set color and unused codes
//   finish in the accept cycle; the response is registered and shows on the
//   next cycle, so they run at one per cycle while rsp_ready stays high. Read
//   cell waits in S_READ for the registered memory read data. A put char that
//   scrolls blanks one screen row, SCREEN_WIDTH cells, through the single write
//   port. Clear writes every cell.
//   Scrolling does not move cells: a top-row offset rotates the row mapping
//   and only the row that becomes the new bottom row is blanked.
//   Reset: the store is swept to 0x0F20 cell by cell; req_ready stays low
//   during that pass.
//   Stalls: the response register holds a finished result while rsp_ready is
//   low; a new request is taken only when that register is free or being
//   emptied in the same cycle.
module text_console_cell_writer import tcw_pkg::*; #(
  parameter int SCREEN_WIDTH  = 80,
  parameter int SCREEN_HEIGHT = 25
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int CELL_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(SCREEN_WIDTH - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(SCREEN_HEIGHT - 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELL_COUNT - 1);

  // Registers
  state_t            state, state_next;
  logic [COL_W-1:0]  cur_x, cur_x_next;
  logic [ROW_W-1:0]  cur_y, cur_y_next;
  logic [ROW_W-1:0]  top, top_next;
  logic [7:0]        attr, attr_next;
  logic [ADDR_W-1:0] sweep_addr, sweep_addr_next;
  logic [ADDR_W-1:0] sweep_last, sweep_last_next;
  logic              sweep_result, sweep_result_next;
  rsp_t              pend, pend_next;

  // Memory port signals
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [CELL_W-1:0] rd_data;

  logic              accept, slot_free, out_load;
  rsp_t              out_next;
  logic [CELL_W-1:0] blank;

  // Put char intermediates
  logic              pc_write, pc_wrap, pc_scroll;
  logic [COL_W:0]    pc_x;
  logic [ROW_W:0]    pc_y;
  logic [COL_W-1:0]  sat_col;
  logic [ROW_W-1:0]  sat_row;
  logic [ADDR_W-1:0] cur_index, read_index;

  // Screen row to storage row through the rotating top offset
  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] r,
                                                input logic [ROW_W-1:0] t);
    logic [ROW_W:0] s;
    s = {1'b0, r} + {1'b0, t};
    if (s >= (ROW_W+1)'(SCREEN_HEIGHT)) begin
      s = s - (ROW_W+1)'(SCREEN_HEIGHT);
    end
    return s[ROW_W-1:0];
  endfunction

  tcw_screen_ram #(
    .DEPTH  (CELL_COUNT),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign slot_free = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE) && slot_free;
  assign accept    = req_valid && req_ready;
  assign blank     = {attr, CH_SPACE};

  // Address math
  assign sat_col    = (req.column >= COL_W'(SCREEN_WIDTH)) ? LAST_COL : req.column;
  assign sat_row    = (req.row >= ROW_W'(SCREEN_HEIGHT)) ? LAST_ROW : req.row;
  assign cur_index  = ADDR_W'(phys_row(cur_y, top) * SCREEN_WIDTH + cur_x);
  assign read_index = ADDR_W'(phys_row(sat_row, top) * SCREEN_WIDTH + sat_col);

  // Cursor movement for put char
  always_comb begin
    pc_write  = (req.char_code != CH_NEWLINE) && (req.char_code != CH_RETURN);
    pc_x      = pc_write ? ({1'b0, cur_x} + 1'b1) : '0;
    pc_y      = (req.char_code == CH_NEWLINE) ? ({1'b0, cur_y} + 1'b1) : {1'b0, cur_y};
    pc_wrap   = (pc_x >= (COL_W+1)'(SCREEN_WIDTH));
    if (pc_wrap) begin
      pc_x = '0;
      pc_y = pc_y + 1'b1;
    end
    pc_scroll = (pc_y >= (ROW_W+1)'(SCREEN_HEIGHT));
    if (pc_scroll) begin
      pc_y = {1'b0, LAST_ROW};
    end
  end

  // Next state and datapath control
  always_comb begin
    state_next        = state;
    cur_x_next        = cur_x;
    cur_y_next        = cur_y;
    top_next          = top;
    attr_next         = attr;
    sweep_addr_next   = sweep_addr;
    sweep_last_next   = sweep_last;
    sweep_result_next = sweep_result;
    pend_next         = pend;
    mem_we            = 1'b0;
    mem_waddr         = sweep_addr;
    mem_wdata         = blank;
    rd_en             = 1'b0;
    rd_addr           = read_index;
    out_load          = 1'b0;
    out_next          = '0;
    out_next.cursor_column = cur_x;
    out_next.cursor_line   = cur_y;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (req.func)
            FUNC_PUT_CHAR: begin
              mem_we     = pc_write;
              mem_waddr  = cur_index;
              mem_wdata  = {attr, req.char_code};
              cur_x_next = pc_x[COL_W-1:0];
              cur_y_next = pc_y[ROW_W-1:0];
              if (pc_scroll) begin
                // Old top row becomes the new bottom row; blank it
                top_next          = (top == LAST_ROW) ? '0 : top + 1'b1;
                sweep_addr_next   = ADDR_W'(top * SCREEN_WIDTH);
                sweep_last_next   = ADDR_W'(top * SCREEN_WIDTH + SCREEN_WIDTH - 1);
                sweep_result_next = 1'b1;
                pend_next         = '0;
                pend_next.cursor_column = pc_x[COL_W-1:0];
                pend_next.cursor_line   = LAST_ROW;
                pend_next.scrolled      = 1'b1;
                state_next        = S_SWEEP;
              end else begin
                out_load = 1'b1;
                out_next.cursor_column = pc_x[COL_W-1:0];
                out_next.cursor_line   = pc_y[ROW_W-1:0];
              end
            end
            FUNC_CLEAR: begin
              cur_x_next        = '0;
              cur_y_next        = '0;
              sweep_addr_next   = '0;
              sweep_last_next   = LAST_ADDR;
              sweep_result_next = 1'b1;
              pend_next         = '0;
              state_next        = S_SWEEP;
            end
            FUNC_SET_CURSOR: begin
              cur_x_next = sat_col;
              cur_y_next = sat_row;
              out_load   = 1'b1;
              out_next.cursor_column = sat_col;
              out_next.cursor_line   = sat_row;
            end
            FUNC_SET_COLOR: begin
              attr_next = {req.background, req.foreground};
              out_load  = 1'b1;
            end
            FUNC_READ_CELL: begin
              rd_en      = 1'b1;
              state_next = S_READ;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        if (slot_free) begin
          out_load           = 1'b1;
          out_next.cell_word = rd_data;
          state_next         = S_IDLE;
        end
      end
      S_SWEEP: begin
        mem_we = 1'b1;
        if (sweep_addr == sweep_last) begin
          state_next = sweep_result ? S_DONE : S_IDLE;
        end else begin
          sweep_addr_next = sweep_addr + 1'b1;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          out_load   = 1'b1;
          out_next   = pend;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers; reset starts the store-clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_SWEEP;
      cur_x        <= '0;
      cur_y        <= '0;
      top          <= '0;
      attr         <= ATTR_RESET;
      sweep_addr   <= '0;
      sweep_last   <= LAST_ADDR;
      sweep_result <= 1'b0;
    end else begin
      state        <= state_next;
      cur_x        <= cur_x_next;
      cur_y        <= cur_y_next;
      top          <= top_next;
      attr         <= attr_next;
      sweep_addr   <= sweep_addr_next;
      sweep_last   <= sweep_last_next;
      sweep_result <= sweep_result_next;
    end
  end

  // Pending result for the sweeping operations (clear, scrolling put char)
  always_ff @(posedge clk) begin
    pend <= pend_next;
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp <= out_next;
    end
  end

  // Checks
  a_top_in_range: assert property (@(posedge clk) disable iff (rst)
    top <= LAST_ROW)
    else $error("top row offset out of range");

  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    (cur_x <= LAST_COL) && (cur_y <= LAST_ROW))
    else $error("cursor outside the screen");

  a_sweep_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP) |-> (sweep_addr <= sweep_last))
    else $error("sweep address ran past its end");

  a_read_response: assert property (@(posedge clk) disable iff (rst)
    (accept && (req.func == FUNC_READ_CELL)) |=> (state == S_READ))
    else $error("read cell did not wait for memory data");

endmodule

>>> rtl/tcw_screen_ram.sv
// Screen cell store: one write port, one read port, registered read data.
// Depends on tcw_pkg for the cell width.
module tcw_screen_ram import tcw_pkg::*; #(
  parameter int DEPTH  = 2000,
  parameter int ADDR_W = 11
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [CELL_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> verif/text_console_cell_writer_tb.sv
// Self-checking testbench for the text console cell writer.
// Depends on tcw_pkg and the text_console_cell_writer RTL; it keeps its own
// copy of the screen, cursor and attribute to predict every response.
`timescale 1ns / 100ps

module text_console_cell_writer_tb;
  import tcw_pkg::*;

  localparam int SCREEN_WIDTH  = 80;
  localparam int SCREEN_HEIGHT = 25;
  localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int RANDOM_ITEMS  = 1400;
  localparam int IDLE_PERCENT  = 13;

  // func codes the block treats as no operation
  localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  text_console_cell_writer #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow copy of the console state
  logic [15:0] shadow_screen [CELL_COUNT];
  int          cur_x;
  int          cur_y;
  logic [7:0]  cur_attr;

  req_t pending_reqs [$];
  rsp_t expected_rsps [$];

  int  errors        = 0;
  int  items_taken   = 0;
  int  rsps_checked  = 0;
  int  directed_cnt  = 0;
  int  scroll_cnt    = 0;
  int  clear_cnt     = 0;
  int  read_cnt      = 0;
  int  cycle_count   = 0;
  int  cycle_limit   = 32'h7fff_ffff;
  int  cycle_budget  = 0;
  bit  req_taken     = 1'b0;

  // no idling on either side for a stretch in the middle of the run
  function automatic bit take_break();
    if (items_taken >= 400 && items_taken < 700)
      return 1'b0;
    return $urandom_range(99) < IDLE_PERCENT;
  endfunction

  // apply one operation to the shadow console and return the response it gives
  function automatic rsp_t apply_console_op(req_t r);
    rsp_t o;
    int   col;
    int   row;
    o   = '0;
    col = (r.column >= SCREEN_WIDTH) ? SCREEN_WIDTH - 1 : r.column;
    row = (r.row >= SCREEN_HEIGHT) ? SCREEN_HEIGHT - 1 : r.row;
    case (r.func)
      FUNC_PUT_CHAR: begin
        if (r.char_code == CH_NEWLINE) begin
          cur_x = 0;
          cur_y++;
        end else if (r.char_code == CH_RETURN) begin
          cur_x = 0;
        end else begin
          shadow_screen[cur_y * SCREEN_WIDTH + cur_x] = {cur_attr, r.char_code};
          cur_x++;
        end
        if (cur_x >= SCREEN_WIDTH) begin
          cur_x = 0;
          cur_y++;
        end
        // moved below the last row: scroll up and blank the bottom row
        if (cur_y >= SCREEN_HEIGHT) begin
          for (int i = SCREEN_WIDTH; i < CELL_COUNT; i++)
            shadow_screen[i - SCREEN_WIDTH] = shadow_screen[i];
          for (int i = CELL_COUNT - SCREEN_WIDTH; i < CELL_COUNT; i++)
            shadow_screen[i] = {cur_attr, CH_SPACE};
          cur_y      = SCREEN_HEIGHT - 1;
          o.scrolled = 1'b1;
          scroll_cnt++;
        end
      end
      FUNC_CLEAR: begin
        for (int i = 0; i < CELL_COUNT; i++)
          shadow_screen[i] = {cur_attr, CH_SPACE};
        cur_x = 0;
        cur_y = 0;
        clear_cnt++;
      end
      FUNC_SET_CURSOR: begin
        cur_x = col;
        cur_y = row;
      end
      FUNC_SET_COLOR: begin
        cur_attr = {r.background, r.foreground};
      end
      FUNC_READ_CELL: begin
        o.cell_word = shadow_screen[row * SCREEN_WIDTH + col];
        read_cnt++;
      end
      default: ;
    endcase
    o.cursor_column = cur_x[COL_W-1:0];
    o.cursor_line   = cur_y[ROW_W-1:0];
    return o;
  endfunction

  function automatic req_t make_op(logic [2:0] f, logic [7:0] ch, logic [6:0] col,
                                   logic [4:0] row, logic [3:0] fg, logic [3:0] bg);
    req_t r;
    r.func       = f;
    r.char_code  = ch;
    r.column     = col;
    r.row        = row;
    r.foreground = fg;
    r.background = bg;
    return r;
  endfunction

  // every field random, func as given
  function automatic req_t random_op(logic [2:0] f);
    return make_op(f, 8'($urandom_range(255)), COL_W'($urandom_range(127)),
                   ROW_W'($urandom_range(31)), 4'($urandom_range(15)),
                   4'($urandom_range(15)));
  endfunction

  // queue one transaction and add its worst-case cost to the cycle budget
  task automatic enqueue(req_t r);
    pending_reqs.push_back(r);
    if (r.func == FUNC_CLEAR)
      cycle_budget += CELL_COUNT + 2 + 40;
    else
      cycle_budget += SCREEN_WIDTH + 2 + 40;
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  // monitor: check responses, predict on accepted requests, watch the clock
  always @(posedge clk) begin
    rsp_t want;
    cycle_count++;
    if (cycle_count > cycle_limit) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("simulation failed");
      $finish;
    end else begin
      if (!rst && rsp_valid && rsp_ready) begin
        if (expected_rsps.size() == 0) begin
          errors++;
          $display("%0t: response with none expected, actual %p", $time, rsp);
        end else begin
          want = expected_rsps.pop_front();
          check_field("cursor_column", want.cursor_column, rsp.cursor_column);
          check_field("cursor_line", want.cursor_line, rsp.cursor_line);
          check_field("scrolled", want.scrolled, rsp.scrolled);
          check_field("cell_word", want.cell_word, rsp.cell_word);
          rsps_checked++;
        end
      end
      req_taken = !rst && req_valid && req_ready;
      if (req_taken) begin
        expected_rsps.push_back(apply_console_op(req));
        items_taken++;
      end
    end
  end

  // driver: present the next pending request, with random gaps
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_taken) begin
      if (pending_reqs.size() != 0 && !take_break()) begin
        req       <= pending_reqs.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
    rsp_ready <= !rst && !take_break();
  end

  initial begin
    req_t r;
    int   n;
    int   k;
    for (int i = 0; i < CELL_COUNT; i++)
      shadow_screen[i] = {ATTR_RESET, CH_SPACE};
    cur_x    = 0;
    cur_y    = 0;
    cur_attr = ATTR_RESET;

    // directed: reset contents, saturation, colors, wrap, scroll, clear, spare codes
    enqueue(make_op(FUNC_READ_CELL, 8'h00, 7'd0, 5'd0, 4'h0, 4'h0));
    enqueue(make_op(FUNC_READ_CELL, 8'h00, 7'd127, 5'd31, 4'h0, 4'h0));
    enqueue(make_op(FUNC_PUT_CHAR, 8'h41, 7'd0, 5'd0, 4'h0, 4'h0));
    enqueue(make_op(FUNC_PUT_CHAR, 8'hFF, 7'd0, 5'd0, 4'h0, 4'h0));
    enqueue(make_op(FUNC_PUT_CHAR, 8'h00, 7'd0, 5'd0, 4'h0, 4'h0));
    enqueue(make_op(FUNC_SET_COLOR, 8'h00, 7'd0, 5'd0, 4'hE, 4'h1));
    enqueue(make_op(FUNC_PUT_CHAR, 8'h42, 7'd0, 5'd0, 4'h0, 4'h0));
    enqueue(make_op(FUNC_READ_CELL, 8'h00, 7'd3, 5'd0, 4'h0, 4'h0));
    enqueue(make_op(FUNC_PUT_CHAR, CH_RETURN, 7'd0, 5'd0, 4'h0, 4'h0));
    enqueue(make_op(FUNC_PUT_CHAR, CH_NEWLINE, 7'd0, 5'd0, 4'h0, 4'h0));
    enqueue(make_op(FUNC_SET_CURSOR, 8'h00, 7'd127, 5'd31, 4'h0, 4'h0));
    enqueue(make_op(FUNC_PUT_CHAR, 8'h5A, 7'd0, 5'd0, 4'h0, 4'h0));
    enqueue(make_op(FUNC_READ_CELL, 8'h00, 7'd79, 5'd23, 4'h0, 4'h0));
    enqueue(make_op(FUNC_PUT_CHAR, CH_NEWLINE, 7'd0, 5'd0, 4'h0, 4'h0));
    enqueue(make_op(FUNC_SET_CURSOR, 8'h00, 7'd5, 5'd24, 4'h0, 4'h0));
    enqueue(make_op(FUNC_PUT_CHAR, CH_RETURN, 7'd0, 5'd0, 4'h0, 4'h0));
    enqueue(make_op(FUNC_SET_COLOR, 8'h00, 7'd0, 5'd0, 4'hF, 4'hF));
    enqueue(make_op(FUNC_CLEAR, 8'h00, 7'd0, 5'd0, 4'h0, 4'h0));
    enqueue(make_op(FUNC_READ_CELL, 8'h00, 7'd40, 5'd12, 4'h0, 4'h0));
    enqueue(make_op(FUNC_SET_COLOR, 8'h00, 7'd0, 5'd0, 4'h0, 4'h0));
    enqueue(make_op(FUNC_SPARE_LO, 8'h41, 7'd9, 5'd9, 4'h3, 4'h3));
    enqueue(make_op(FUNC_SPARE_LO + 3'd1, 8'hFF, 7'd127, 5'd31, 4'hF, 4'hF));
    enqueue(make_op(FUNC_SPARE_HI, 8'h0A, 7'd1, 5'd1, 4'h1, 4'h1));
    enqueue(make_op(FUNC_SET_CURSOR, 8'h00, 7'd0, 5'd0, 4'h0, 4'h0));
    enqueue(make_op(FUNC_READ_CELL, 8'h00, 7'd0, 5'd0, 4'h0, 4'h0));
    directed_cnt = pending_reqs.size();

    // random: mostly text runs, with jumps to the bottom right to force wraps and scrolls
    while (pending_reqs.size() < directed_cnt + RANDOM_ITEMS) begin
      k = $urandom_range(99);
      if (k < 45 || (k >= 45 && k < 60)) begin
        if (k >= 45) begin
          r        = random_op(FUNC_SET_CURSOR);
          r.column = COL_W'($urandom_range(127, SCREEN_WIDTH - 10));
          r.row    = ROW_W'($urandom_range(31, SCREEN_HEIGHT - 5));
          enqueue(r);
        end
        n = $urandom_range(40, 1);
        repeat (n) begin
          r = random_op(FUNC_PUT_CHAR);
          case ($urandom_range(24))
            0, 1:    r.char_code = CH_NEWLINE;
            2:       r.char_code = CH_RETURN;
            default: ;
          endcase
          enqueue(r);
        end
      end else if (k < 70) begin
        enqueue(random_op(FUNC_SET_COLOR));
      end else if (k < 85) begin
        r = random_op(FUNC_READ_CELL);
        if ($urandom_range(1)) begin
          r.column = COL_W'($urandom_range(SCREEN_WIDTH - 1));
          r.row    = ROW_W'($urandom_range(SCREEN_HEIGHT - 1, SCREEN_HEIGHT - 6));
        end
        enqueue(r);
      end else if (k < 90) begin
        enqueue(random_op(FUNC_SET_CURSOR));
      end else if (k < 93) begin
        enqueue(random_op(FUNC_CLEAR));
      end else if (k < 95) begin
        enqueue(random_op(3'($urandom_range(FUNC_SPARE_HI, FUNC_SPARE_LO))));
      end else begin
        // a run of newlines scrolls the screen repeatedly
        n = $urandom_range(30, 1);
        repeat (n) begin
          r           = random_op(FUNC_PUT_CHAR);
          r.char_code = CH_NEWLINE;
          enqueue(r);
        end
      end
    end
    cycle_limit = 4 * (cycle_budget + CELL_COUNT + 200);

    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // drain: all requests taken, all responses seen, then a short quiet period
    while (pending_reqs.size() != 0 || req_valid)
      @(posedge clk);
    while (expected_rsps.size() != 0)
      @(posedge clk);
    repeat (SCREEN_WIDTH + 8) @(posedge clk);

    $display("Checked %0d responses for %0d requests (%0d directed).",
             rsps_checked, items_taken, directed_cnt);
    $display("Covered %0d scrolls, %0d clears and %0d cell reads; %0d mismatches.",
             scroll_cnt, clear_cnt, read_cnt, errors);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

>>> files.f
rtl/tcw_pkg.sv
rtl/tcw_screen_ram.sv
rtl/text_console_cell_writer.sv
verif/text_console_cell_writer_tb.sv
